>>> hw/rtl/cwc_pkg.sv
// shared types, constants and codes for the congestion window engine
package cwc_pkg;

   localparam int unsigned FuncWidth   = 2;
   localparam int unsigned WindowWidth = 13;
   localparam int unsigned SegWidth    = 15;
   localparam int unsigned SeqWidth    = 32;
   localparam int unsigned ThrWidth    = 32;
   localparam int unsigned ProdWidth   = WindowWidth + SegWidth;
   localparam int unsigned AddrWidth   = 3;
   localparam int unsigned DataWidth   = 32;

   localparam logic [WindowWidth-1:0] MaxWindow = 13'd4096;
   localparam logic [SegWidth-1:0]    SegReset  = 15'd1024;
   localparam logic [ThrWidth-1:0]    ThrReset  = 32'd65536;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_RESTART = 2'd0,
      FUNC_ROUND   = 2'd1,
      FUNC_ACK     = 2'd2,
      FUNC_TIMEOUT = 2'd3
   } func_type;

   typedef enum logic {
      CSR_SEGMENT   = 1'b0,
      CSR_THRESHOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SegWidth-1:0] segment_bytes;
      logic [ThrWidth-1:0] initial_threshold;
   } cfg_type;

   typedef struct packed {
      func_type               func;
      logic [SeqWidth-1:0]    ack_number;
      logic [WindowWidth-1:0] sent_count;
      logic                   end_of_data;
   } req_type;

   typedef struct packed {
      logic [WindowWidth-1:0] window_packets;
      logic [ThrWidth-1:0]    threshold_bytes;
      logic                   mode;
      logic [SeqWidth-1:0]    next_sequence;
      logic                   round_over;
      logic                   fast_retransmit;
      logic                   timed_out;
      logic [WindowWidth-1:0] acks_pending;
      logic                   data_done;
   } rsp_type;

endpackage

>>> hw/rtl/cwc_req_if.sv
// request channel interface carrying one congestion event
interface cwc_req_if;
   logic                               valid;
   logic                               ready;
   logic [cwc_pkg::FuncWidth-1:0]      func;
   logic [cwc_pkg::SeqWidth-1:0]       ack_number;
   logic [cwc_pkg::WindowWidth-1:0]    sent_count;
   logic                               end_of_data;

   modport source (output valid, func, ack_number, sent_count, end_of_data, input ready);
   modport sink   (input valid, func, ack_number, sent_count, end_of_data, output ready);
endinterface

>>> hw/rtl/cwc_rsp_if.sv
// result channel interface carrying the window state after an event
interface cwc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cwc_pkg::WindowWidth-1:0]    window_packets;
   logic [cwc_pkg::ThrWidth-1:0]       threshold_bytes;
   logic                               mode;
   logic [cwc_pkg::SeqWidth-1:0]       next_sequence;
   logic                               round_over;
   logic                               fast_retransmit;
   logic                               timed_out;
   logic [cwc_pkg::WindowWidth-1:0]    acks_pending;
   logic                               data_done;

   modport source (output valid, window_packets, threshold_bytes, mode, next_sequence,
                   round_over, fast_retransmit, timed_out, acks_pending, data_done,
                   input ready);
   modport sink   (input valid, window_packets, threshold_bytes, mode, next_sequence,
                   round_over, fast_retransmit, timed_out, acks_pending, data_done,
                   output ready);
endinterface

>>> hw/rtl/cwc_csr.sv
// apb configuration registers: segment size and initial threshold
module cwc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cwc_pkg::AddrWidth-1:0]       paddr,
   input  logic [cwc_pkg::DataWidth-1:0]       pwdata,
   output logic [cwc_pkg::DataWidth-1:0]       prdata,
   output logic                                pready,
   output cwc_pkg::cfg_type                    cfg
);

   logic [cwc_pkg::SegWidth-1:0] seg_ff, seg_in;
   logic [cwc_pkg::ThrWidth-1:0] thr_ff, thr_in;
   cwc_pkg::csr_index_type       index;
   logic                         wr_en;

   assign pready = 1'b1;
   assign index  = cwc_pkg::csr_index_type'(paddr[2]);
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      seg_in = seg_ff;
      thr_in = thr_ff;
      if (wr_en) begin
         unique case (index)
            cwc_pkg::CSR_SEGMENT:   seg_in = pwdata[cwc_pkg::SegWidth-1:0];
            cwc_pkg::CSR_THRESHOLD: thr_in = pwdata[cwc_pkg::ThrWidth-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         cwc_pkg::CSR_SEGMENT:   prdata = cwc_pkg::DataWidth'(seg_ff);
         cwc_pkg::CSR_THRESHOLD: prdata = cwc_pkg::DataWidth'(thr_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= cwc_pkg::SegReset;
         thr_ff <= cwc_pkg::ThrReset;
      end else begin
         seg_ff <= seg_in;
         thr_ff <= thr_in;
      end
   end

   assign cfg.segment_bytes     = seg_ff;
   assign cfg.initial_threshold = thr_ff;

endmodule

>>> hw/rtl/cwc_core.sv
// congestion state registers and the combinational event update
module cwc_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  cwc_pkg::req_type   req,
   input  cwc_pkg::cfg_type   cfg,
   output cwc_pkg::rsp_type   res
);

   logic [cwc_pkg::WindowWidth-1:0] window_ff, window_in;
   logic [cwc_pkg::ThrWidth-1:0]    thr_ff, thr_in;
   logic                            mode_ff, mode_in;
   logic [cwc_pkg::SeqWidth-1:0]    seq_ff, seq_in;
   logic [cwc_pkg::SeqWidth-1:0]    last_ack_ff, last_ack_in;
   logic [1:0]                      dup_ff, dup_in;
   logic [cwc_pkg::WindowWidth-1:0] pending_ff, pending_in;
   logic                            done_ff, done_in;

   logic [cwc_pkg::ProdWidth-1:0]   win_prod;
   logic [cwc_pkg::ProdWidth-1:0]   sent_prod;
   logic [cwc_pkg::ProdWidth-1:0]   sat_prod;
   logic [cwc_pkg::ProdWidth:0]     grow_prod;
   logic [cwc_pkg::WindowWidth:0]   win_dbl;
   logic                            dbl_sat;
   logic [cwc_pkg::WindowWidth-1:0] win_slow;
   logic [cwc_pkg::WindowWidth-1:0] win_avoid;
   logic                            enter_avoid;
   logic [cwc_pkg::WindowWidth-1:0] sent_clip;
   logic [cwc_pkg::WindowWidth-1:0] pending_dec;
   logic [1:0]                      dup_upd;
   logic                            done_eff;
   logic                            end_round;
   logic                            round_over, fast, tout;

   // window times segment size, shared by collapse and slow start check
   assign win_prod  = cwc_pkg::ProdWidth'(window_ff) * cwc_pkg::ProdWidth'(cfg.segment_bytes);
   assign sent_clip = (req.sent_count > window_ff) ? window_ff : req.sent_count;
   assign sent_prod = cwc_pkg::ProdWidth'(sent_clip) * cwc_pkg::ProdWidth'(cfg.segment_bytes);

   // slow start growth, saturated
   assign win_dbl   = {window_ff, 1'b0};
   assign dbl_sat   = win_dbl > {1'b0, cwc_pkg::MaxWindow};
   assign win_slow  = dbl_sat ? cwc_pkg::MaxWindow : win_dbl[cwc_pkg::WindowWidth-1:0];
   assign sat_prod  = cwc_pkg::ProdWidth'(cfg.segment_bytes) * cwc_pkg::ProdWidth'(cwc_pkg::MaxWindow);
   assign grow_prod = dbl_sat ? {1'b0, sat_prod} : {win_prod, 1'b0};
   assign enter_avoid = cwc_pkg::ThrWidth'(grow_prod) >= thr_ff;
   assign win_avoid = (window_ff < cwc_pkg::MaxWindow) ? window_ff + 1'b1 : window_ff;

   assign pending_dec = pending_ff - 1'b1;
   assign dup_upd     = (last_ack_ff == req.ack_number) ? dup_ff + 1'b1 : 2'd0;

   always_comb begin
      window_in   = window_ff;
      thr_in      = thr_ff;
      mode_in     = mode_ff;
      seq_in      = seq_ff;
      last_ack_in = last_ack_ff;
      dup_in      = dup_ff;
      pending_in  = pending_ff;
      done_in     = done_ff;
      done_eff    = done_ff;
      end_round   = 1'b0;
      round_over  = 1'b0;
      fast        = 1'b0;
      tout        = 1'b0;

      unique case (req.func)
         cwc_pkg::FUNC_RESTART: begin
            window_in  = cwc_pkg::WindowWidth'(1);
            thr_in     = cfg.initial_threshold;
            mode_in    = 1'b0;
            seq_in     = cwc_pkg::SeqWidth'(1);
            pending_in = '0;
            done_in    = 1'b0;
         end
         cwc_pkg::FUNC_ROUND: begin
            if (!mode_ff) begin
               seq_in = seq_ff + cwc_pkg::SeqWidth'(sent_prod);
            end
            done_eff   = done_ff | req.end_of_data;
            done_in    = done_eff;
            pending_in = sent_clip;
            if (sent_clip == '0) begin
               round_over = 1'b1;
               end_round  = 1'b1;
            end
         end
         cwc_pkg::FUNC_ACK: begin
            if (pending_ff != '0) begin
               seq_in      = req.ack_number;
               last_ack_in = req.ack_number;
               dup_in      = dup_upd;
               if (dup_upd == 2'd2) begin
                  // third equal ack: fast retransmit
                  thr_in      = cwc_pkg::ThrWidth'(win_prod >> 1);
                  window_in   = cwc_pkg::WindowWidth'(1);
                  mode_in     = 1'b0;
                  pending_in  = '0;
                  dup_in      = 2'd0;
                  last_ack_in = '0;
                  round_over  = 1'b1;
                  fast        = 1'b1;
               end else begin
                  pending_in = pending_dec;
                  if (pending_dec == '0) begin
                     round_over = 1'b1;
                     end_round  = 1'b1;
                  end
               end
            end
         end
         cwc_pkg::FUNC_TIMEOUT: begin
            if (pending_ff != '0) begin
               thr_in     = cwc_pkg::ThrWidth'(win_prod >> 1);
               window_in  = cwc_pkg::WindowWidth'(1);
               mode_in    = 1'b0;
               pending_in = '0;
               round_over = 1'b1;
               tout       = 1'b1;
            end
         end
      endcase

      if (end_round && !done_eff) begin
         if (!mode_ff) begin
            window_in = win_slow;
            mode_in   = enter_avoid;
         end else begin
            window_in = win_avoid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= cwc_pkg::WindowWidth'(1);
         thr_ff      <= cwc_pkg::ThrReset;
         mode_ff     <= 1'b0;
         seq_ff      <= cwc_pkg::SeqWidth'(1);
         last_ack_ff <= '0;
         dup_ff      <= 2'd0;
         pending_ff  <= '0;
         done_ff     <= 1'b0;
      end else if (step) begin
         window_ff   <= window_in;
         thr_ff      <= thr_in;
         mode_ff     <= mode_in;
         seq_ff      <= seq_in;
         last_ack_ff <= last_ack_in;
         dup_ff      <= dup_in;
         pending_ff  <= pending_in;
         done_ff     <= done_in;
      end
   end

   assign res.window_packets  = window_in;
   assign res.threshold_bytes = thr_in;
   assign res.mode            = mode_in;
   assign res.next_sequence   = seq_in;
   assign res.round_over      = round_over;
   assign res.fast_retransmit = fast;
   assign res.timed_out       = tout;
   assign res.acks_pending    = pending_in;
   assign res.data_done       = done_in;

endmodule

>>> hw/rtl/tcp_congestion_window_control.sv
// top level: request register, event update core, result register and csr port
// path: request register, then the core update into the result register
// throughput: one request per cycle while the result side does not stall
// reset: synchronous, clears both channel stages and loads the window state defaults
// reset: segment size 1024, initial threshold 65536, window 1, sequence 1
module tcp_congestion_window_control (
   input  logic                          clock,
   input  logic                          reset,
   cwc_req_if.sink                       req_bus,
   cwc_rsp_if.source                     rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [cwc_pkg::AddrWidth-1:0] paddr,
   input  logic [cwc_pkg::DataWidth-1:0] pwdata,
   output logic [cwc_pkg::DataWidth-1:0] prdata,
   output logic                          pready
);

   cwc_pkg::cfg_type cfg;
   cwc_pkg::req_type req_ff, req_in;
   cwc_pkg::rsp_type rsp_ff, res;
   logic             in_valid_ff, in_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;

   cwc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cwc_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .res   (res)
   );

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      req_in.func        = cwc_pkg::func_type'(req_bus.func);
      req_in.ack_number  = req_bus.ack_number;
      req_in.sent_count  = req_bus.sent_count;
      req_in.end_of_data = req_bus.end_of_data;
      in_valid_in        = req_bus.ready ? req_bus.valid : in_valid_ff;
      rsp_valid_in       = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.window_packets  = rsp_ff.window_packets;
   assign rsp_bus.threshold_bytes = rsp_ff.threshold_bytes;
   assign rsp_bus.mode            = rsp_ff.mode;
   assign rsp_bus.next_sequence   = rsp_ff.next_sequence;
   assign rsp_bus.round_over      = rsp_ff.round_over;
   assign rsp_bus.fast_retransmit = rsp_ff.fast_retransmit;
   assign rsp_bus.timed_out       = rsp_ff.timed_out;
   assign rsp_bus.acks_pending    = rsp_ff.acks_pending;
   assign rsp_bus.data_done       = rsp_ff.data_done;

   // window stays in range
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_bus.window_packets != '0) &&
                  (rsp_bus.window_packets <= cwc_pkg::MaxWindow))
      else $error("window out of range");

   // a collapse ends the round and resets the window
   assert property (@(posedge clock) disable iff (reset)
      advance && (res.fast_retransmit || res.timed_out) |->
         res.round_over && (res.window_packets == cwc_pkg::WindowWidth'(1)) &&
         !res.mode && (res.acks_pending == '0))
      else $error("collapse left inconsistent state");

   // fast retransmit and timeout never together
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.fast_retransmit && rsp_bus.timed_out))
      else $error("both collapse flags set");

   // a held request is not lost while the result side stalls
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(req_ff))
      else $error("stalled request dropped");

endmodule
